// ===== hw/rtl/plel_pkg.sv =====
// ----------------------------------------------------------------------------
// plel_pkg
// Shared types and constants for the positional list engine: request kinds,
// result status codes, the command bundle that goes to every list cell, and
// the stream bus widths.
// ----------------------------------------------------------------------------
package plel_pkg;

  // Default number of list entries.
  localparam int DEPTH_DEF = 32;

  // Width of position and length compares, wide enough for any depth up to 256
  // and any 6-bit position.
  localparam int CMP_W = 10;

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  // Stream bus widths: input tdata carries position and value, output tdata
  // carries status, read value, found position and length.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_LOCATE = 3'd3,
    KIND_CLEAR  = 3'd4
  } plel_kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } plel_status_e;

  // Command broadcast to all cells for one transaction.
  typedef struct packed {
    logic               ins;    // insert succeeds: open a gap and load
    logic               del;    // delete succeeds: close the gap
    logic [CMP_W-1:0]   pos;    // one-based position, zero extended
    logic [CMP_W-1:0]   count;  // current list length
    logic [VALUE_W-1:0] value;  // value to insert or search for
  } plel_cmd_t;

endpackage

// ===== hw/rtl/plel_cell.sv =====
// ----------------------------------------------------------------------------
// plel_cell
// One list slot. Holds one entry, loads the new value on an insert at it,
// takes its left neighbor's entry on an insert before it and its right
// neighbor's entry on a delete at or before it, and reports whether it is
// the addressed slot and whether it matches the search value.
// ----------------------------------------------------------------------------
module plel_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  plel_pkg::plel_cmd_t       cmd_i,
  input  logic [plel_pkg::VALUE_W-1:0] left_i,
  input  logic [plel_pkg::VALUE_W-1:0] right_i,
  output logic [plel_pkg::VALUE_W-1:0] data_o,
  output logic                      pick_o,
  output logic                      hit_o
);
  import plel_pkg::*;

  // One-based position of this slot.
  localparam logic [CMP_W-1:0] POS_HERE = CMP_W'(IDX + 1);

  logic [VALUE_W-1:0] data_q, data_d;

  // Shift or load selection for this slot.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (POS_HERE == cmd_i.pos) begin
        data_d = cmd_i.value;
      end else if (POS_HERE > cmd_i.pos) begin
        data_d = left_i;
      end
    end else if (cmd_i.del && (POS_HERE >= cmd_i.pos)) begin
      data_d = right_i;
    end
  end

  // Entry storage; contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Address match and search match for the current request.
  assign pick_o = (POS_HERE == cmd_i.pos);
  assign hit_o  = (data_q == cmd_i.value) && (POS_HERE <= cmd_i.count);
  assign data_o = data_q;

endmodule

// ===== hw/rtl/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed 32-bit values held in a row of cells, with insert,
// delete, get, locate and clear requests and one result per request.
// ----------------------------------------------------------------------------
// Each request on the slave stream (tuser = kind, tdata = position and value)
// is finished in the cycle it is accepted: every cell shifts toward or away
// from its neighbor at once for insert and delete, and all cells compare
// against the search value in parallel for locate. The result lands in an
// output register in the next cycle, and a new request is taken every cycle as
// long as that register is empty or being drained, so the sustained rate is
// one request per clock. Positions are one-based; list contents after reset
// are undefined until written, and only positions up to the current length
// are ever read.
module positional_list_engine_top #(
  parameter int DEPTH = plel_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] kind
  input  logic [plel_pkg::KIND_W-1:0]    s_axis_tuser,
  // [5:0] position, [37:6] value, [39:38] zero
  input  logic [plel_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] status, [34:3] read_value, [40:35] found_position,
  // [46:41] list_length, [47] zero
  output logic [plel_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import plel_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 accept;
  logic [POS_W-1:0]     in_pos;
  logic [VALUE_W-1:0]   in_value;
  plel_kind_e           in_kind;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CMP_W-1:0]     count_ext;
  plel_cmd_t            cmd;

  logic [VALUE_W-1:0]   cell_data [DEPTH];
  logic [DEPTH-1:0]     pick;
  logic [DEPTH-1:0]     hit;
  logic [DEPTH-1:0]     first_hit;

  logic [VALUE_W-1:0]   picked_value;
  logic [POS_W-1:0]     hit_pos;

  plel_status_e         status;
  logic                 ins_ok, del_ok;
  logic [VALUE_W-1:0]   rd_value;
  logic [POS_W-1:0]     found_pos;

  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  // Input unpacking and handshake.
  assign in_pos        = s_axis_tdata[POS_W-1:0];
  assign in_value      = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
  assign in_kind       = plel_kind_e'(s_axis_tuser);
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign count_ext     = CMP_W'(count_q);

  // Requests that change the list, and the length they leave behind.
  always_comb begin
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    count_d = count_q;
    unique case (in_kind)
      KIND_INSERT: begin
        if ((count_ext < CMP_W'(DEPTH)) && (in_pos != '0) &&
            (CMP_W'(in_pos) <= count_ext + CMP_W'(1))) begin
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if ((count_q != '0) && (in_pos != '0) && (CMP_W'(in_pos) <= count_ext)) begin
          del_ok  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Request status and result fields.
  always_comb begin
    status    = ST_OK;
    rd_value  = '0;
    found_pos = '0;
    unique case (in_kind)
      KIND_INSERT: begin
        if (count_ext >= CMP_W'(DEPTH)) begin
          status = ST_FULL;
        end else if ((in_pos == '0) || (CMP_W'(in_pos) > count_ext + CMP_W'(1))) begin
          status = ST_BADPOS;
        end
      end
      KIND_DELETE, KIND_GET: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if ((in_pos == '0) || (CMP_W'(in_pos) > count_ext)) begin
          status = ST_BADPOS;
        end else begin
          rd_value = picked_value;
        end
      end
      KIND_LOCATE: begin
        if (hit == '0) begin
          status = ST_NOTFOUND;
        end else begin
          found_pos = hit_pos;
        end
      end
      default: begin
      end
    endcase
  end

  // Command bundle broadcast along the row of cells.
  always_comb begin
    cmd.ins   = accept && ins_ok;
    cmd.del   = accept && del_ok;
    cmd.pos   = CMP_W'(in_pos);
    cmd.count = count_ext;
    cmd.value = in_value;
  end

  // Row of cells, each wired to its neighbors.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [VALUE_W-1:0] left_data;
    logic [VALUE_W-1:0] right_data;
    if (gi == 0) begin : g_first
      assign left_data = in_value;
    end else begin : g_mid_l
      assign left_data = cell_data[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_data = cell_data[gi];
    end else begin : g_mid_r
      assign right_data = cell_data[gi+1];
    end
    plel_cell #(
      .IDX (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[gi]),
      .pick_o  (pick[gi]),
      .hit_o   (hit[gi])
    );
  end

  // Lowest matching cell, isolated as a one-hot vector.
  assign first_hit = hit & (~hit + DEPTH'(1));

  // Read-out of the addressed cell and encoding of the first match.
  always_comb begin
    picked_value = '0;
    hit_pos      = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pick[i]) begin
        picked_value = picked_value | cell_data[i];
      end
      if (first_hit[i]) begin
        hit_pos = hit_pos | POS_W'(i + 1);
      end
    end
  end

  // Result packing.
  assign m_data_d = {1'b0, POS_W'(count_d), found_pos, rd_value, status};

  // Length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== hw/rtl/plel_checker.sv =====
// ----------------------------------------------------------------------------
// plel_checker
// Port-level checks for the positional list engine, attached to the top level
// by a bind statement.
// ----------------------------------------------------------------------------
module plel_checker #(
  parameter int DEPTH = plel_pkg::DEPTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [plel_pkg::KIND_W-1:0]    s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [plel_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import plel_pkg::*;

  // A result transaction that is stalled stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // With the output register empty, a request is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused while output is empty");

  // A clear yields status ok and an empty list in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_CLEAR) |=>
      m_axis_tvalid && (m_axis_tdata[2:0] == ST_OK) && (m_axis_tdata[46:41] == '0))
    else $error("clear did not empty the list");

  // A failed locate reports no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == ST_NOTFOUND) |-> (m_axis_tdata[40:35] == '0))
    else $error("position reported with not found status");

  // The reported length never exceeds the list depth, checked for depths up to 63.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 63) || (m_axis_tdata[46:41] <= 6'(DEPTH)))
    else $error("list length beyond depth");

endmodule

bind positional_list_engine_top plel_checker #(
  .DEPTH (DEPTH)
) u_plel_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_positional_list_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. A clocked driver feeds
// requests from a queue, and a local list model predicts each result as the
// request is accepted. A clocked monitor compares every result with the
// oldest prediction. Directed requests cover the empty, full and bad position
// cases first. Random phases then fill, drain and mix the list, with idle
// bursts on both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
  import plel_pkg::*;

  localparam int LIST_DEPTH = plel_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES = 60;
  localparam int POS_MAX = 63;

  // Kind codes that the block ignores.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    plel_status_e       status;
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   found_position;
    logic [POS_W-1:0]   list_length;
  } list_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [2:0] kind
  logic [KIND_W-1:0]    s_axis_tuser = '0;
  // [5:0] position, [37:6] value, [39:38] zero
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [2:0] status, [34:3] read_value, [40:35] found_position,
  // [46:41] list_length, [47] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Requests waiting to be offered, and predicted results in order.
  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];

  // Predictor state: the list as the block should hold it.
  logic [VALUE_W-1:0] list_vals[LIST_DEPTH];
  int                 list_len = 0;

  // Stimulus side: list length as the generator expects it, recent values.
  int                 gen_len = 0;
  logic [VALUE_W-1:0] value_pool[$];

  // Flow control.
  bit        idle_en = 1'b1;
  bit        hold_req = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  list_req_t offered_req;

  // Bookkeeping.
  int err_cnt = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_badpos = 0;
  int n_empty = 0;
  int n_notfound = 0;
  int max_len = 0;

  positional_list_engine_top #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock with an 8 ns period.
  always #4 clk_i = ~clk_i;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Applies one request to the list model and returns the result it yields.
  function automatic list_result_t apply_request(list_req_t rq);
    list_result_t res;
    int p;
    res.status = ST_OK;
    res.read_value = '0;
    res.found_position = '0;
    p = rq.pos;
    case (rq.kind)
      KIND_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (int k = list_len; k >= p; k--) list_vals[k] = list_vals[k-1];
          list_vals[p-1] = rq.value;
          list_len++;
        end
      end
      KIND_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.read_value = list_vals[p-1];
          for (int k = p; k < list_len; k++) list_vals[k-1] = list_vals[k];
          list_len--;
        end
      end
      KIND_GET: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (p < 1 || p > list_len) res.status = ST_BADPOS;
        else res.read_value = list_vals[p-1];
      end
      KIND_LOCATE: begin
        // The first matching position wins.
        res.status = ST_NOTFOUND;
        for (int k = 0; k < list_len; k++) begin
          if (res.found_position == 0 && list_vals[k] == rq.value) begin
            res.found_position = POS_W'(k + 1);
            res.status = ST_OK;
          end
        end
      end
      KIND_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.list_length = POS_W'(list_len);
    return res;
  endfunction

  // Queues one request and tracks the length it leaves behind.
  task automatic push_req(logic [KIND_W-1:0] kind, int pos, logic [VALUE_W-1:0] value);
    list_req_t rq;
    rq.kind = kind;
    rq.pos = POS_W'(pos);
    rq.value = value;
    pending_reqs.push_back(rq);
    case (kind)
      KIND_INSERT: begin
        if (gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
        value_pool.push_back(value);
        if (value_pool.size() > 12) void'(value_pool.pop_front());
      end
      KIND_DELETE: begin
        if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      end
      KIND_CLEAR: gen_len = 0;
      default: begin
      end
    endcase
  endtask

  // Queues one random request; ins_pct and del_pct steer the list length.
  task automatic push_random(int ins_pct, int del_pct);
    int r;
    int pos;
    logic [KIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    r = $urandom_range(0, 99);
    if (r < ins_pct) kind = KIND_INSERT;
    else if (r < ins_pct + del_pct) kind = KIND_DELETE;
    else if (r < 97) kind = r[0] ? KIND_LOCATE : KIND_GET;
    else if (r == 97) kind = KIND_CLEAR;
    else kind = KIND_SPARE_LO + KIND_W'($urandom_range(0, KIND_SPARE_HI - KIND_SPARE_LO));

    // Mostly positions inside the list, sometimes anything the field allows.
    if ($urandom_range(0, 99) < 85) begin
      if (kind == KIND_INSERT)
        pos = (gen_len < LIST_DEPTH) ? $urandom_range(1, gen_len + 1) : $urandom_range(0, POS_MAX);
      else
        pos = (gen_len > 0) ? $urandom_range(1, gen_len) : $urandom_range(0, POS_MAX);
    end else begin
      pos = $urandom_range(0, POS_MAX);
    end

    // Reuse recent values so that duplicates and locate hits are common.
    r = $urandom_range(0, 99);
    if (value_pool.size() > 0 && r < ((kind == KIND_LOCATE) ? 60 : 25)) begin
      value = value_pool[$urandom_range(0, value_pool.size() - 1)];
    end else if (r > 93) begin
      case ($urandom_range(0, 3))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'h0000_0000;
        default: value = 32'hFFFF_FFFF;
      endcase
    end else begin
      value = $urandom();
    end
    push_req(kind, pos, value);
  endtask

  // Waits until every queued request has been taken and answered.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Request driver: predicts on each accepted transaction, then offers the
  // next request or idles for a short burst.
  always @(posedge clk_i) begin
    list_result_t res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        res = apply_request(offered_req);
        expected_results.push_back(res);
        n_accepted++;
        case (res.status)
          ST_FULL:     n_full++;
          ST_BADPOS:   n_badpos++;
          ST_EMPTY:    n_empty++;
          ST_NOTFOUND: n_notfound++;
          default: begin
          end
        endcase
        if (list_len > max_len) max_len = list_len;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          offered_req = pending_reqs.pop_front();
          s_axis_tuser <= offered_req.kind;
          s_axis_tdata <= {2'b00, offered_req.value, offered_req.pos};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted transaction against the oldest
  // prediction, then decides whether to stall the next cycle.
  always @(posedge clk_i) begin
    list_result_t want;
    logic [STATUS_W-1:0] got_status;
    logic [VALUE_W-1:0]  got_value;
    logic [POS_W-1:0]    got_found;
    logic [POS_W-1:0]    got_len;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[2:0];
        got_value  = m_axis_tdata[34:3];
        got_found  = m_axis_tdata[40:35];
        got_len    = m_axis_tdata[46:41];
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got_status != want.status)
            report_mismatch($sformatf("result %0d status got %0d want %0d",
                                      n_checked, got_status, want.status));
          if (got_value != want.read_value)
            report_mismatch($sformatf("result %0d read_value got %h want %h",
                                      n_checked, got_value, want.read_value));
          if (got_found != want.found_position)
            report_mismatch($sformatf("result %0d found_position got %0d want %0d",
                                      n_checked, got_found, want.found_position));
          if (got_len != want.list_length)
            report_mismatch($sformatf("result %0d list_length got %0d want %0d",
                                      n_checked, got_len, want.list_length));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Requests on an empty list, positions out of range and the unused kind codes.
    push_req(KIND_GET, 1, 32'h0);
    push_req(KIND_DELETE, 1, 32'h0);
    push_req(KIND_LOCATE, 0, 32'h0);
    push_req(KIND_INSERT, 0, 32'h1234_5678);
    push_req(KIND_INSERT, 2, 32'h1234_5678);
    push_req(KIND_INSERT, 1, 32'h8000_0000);
    push_req(KIND_INSERT, 2, 32'h7FFF_FFFF);
    push_req(KIND_INSERT, 1, 32'hFFFF_FFFF);
    push_req(KIND_INSERT, 2, 32'h0000_0000);
    push_req(KIND_LOCATE, 0, 32'h7FFF_FFFF);
    push_req(KIND_GET, POS_MAX, 32'h0);
    push_req(KIND_GET, 0, 32'h0);
    push_req(KIND_DELETE, 5, 32'h0);
    push_req(KIND_DELETE, 2, 32'h0);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      push_req(KIND_W'(k), POS_MAX, 32'hFFFF_FFFF);
    // Fill to the top, with one repeated value for a first-match locate.
    while (gen_len < LIST_DEPTH)
      push_req(KIND_INSERT, gen_len + 1, (gen_len % 8 == 3) ? 32'h0BAD_F00D : $urandom());
    push_req(KIND_INSERT, 0, 32'h5555_5555);
    push_req(KIND_INSERT, LIST_DEPTH + 1, 32'hAAAA_AAAA);
    push_req(KIND_GET, LIST_DEPTH, 32'h0);
    push_req(KIND_LOCATE, 0, 32'h0BAD_F00D);
    push_req(KIND_DELETE, 1, 32'h0);
    push_req(KIND_GET, LIST_DEPTH, 32'h0);
    push_req(KIND_CLEAR, 0, 32'h0);
    push_req(KIND_GET, 1, 32'h0);
    push_req(KIND_LOCATE, 0, 32'h0);
    wait_drained();

    // Fill-heavy phase, with a long hold-off on the result side.
    for (int i = 0; i < 350; i++) push_random(60, 8);
    hold_req = 1'b1;
    wait_drained();

    // Drain-heavy phase.
    for (int i = 0; i < 350; i++) push_random(15, 55);
    wait_drained();

    // Mixed phase.
    for (int i = 0; i < 350; i++) push_random(35, 30);
    wait_drained();

    // Mixed phase at full rate on both streams.
    idle_en = 1'b0;
    for (int i = 0; i < 400; i++) push_random(35, 30);
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d requests and %0d checked results, longest list %0d.",
             n_accepted, n_checked, max_len);
    $display("Failures seen: full %0d, bad position %0d, empty %0d, not found %0d.",
             n_full, n_badpos, n_empty, n_notfound);
    if (err_cnt == 0) begin
      $display("tb_positional_list_engine_top: done, clean");
    end else begin
      $display("tb_positional_list_engine_top: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Timeout with %0d requests queued and %0d results outstanding.",
             pending_reqs.size(), expected_results.size());
    $display("tb_positional_list_engine_top: done, errors");
    $finish;
  end

endmodule
